FILE: hw/rtl/flag_stuffed_frame_encoder_xor_assert.svh
// assertion macros used by the framer top level
`ifndef FLAG_STUFFED_FRAME_ENCODER_XOR_ASSERT_SVH
`define FLAG_STUFFED_FRAME_ENCODER_XOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define FSFE_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// next-cycle implication
`define FSFE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`else

`define FSFE_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define FSFE_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: hw/rtl/fsfe_pkg.sv
// constants, types and escape helpers for the flag-stuffed framer
package fsfe_pkg;

  localparam logic [7:0] FLAG_BYTE   = 8'h7E;
  localparam logic [7:0] ESC_BYTE    = 8'h7D;
  localparam logic [7:0] ESC_FLAG_LO = 8'h5E;
  localparam logic [7:0] ESC_ESC_LO  = 8'h5D;

  localparam int BurstMax = 6;

  typedef logic [2:0] idx_t;

  // all line bytes caused by one request
  typedef struct packed {
    logic [BurstMax-1:0][7:0] data;
    idx_t                     last_idx;
    logic                     closes;
  } burst_t;

  function automatic logic needs_esc(input logic [7:0] b);
    return (b == FLAG_BYTE) || (b == ESC_BYTE);
  endfunction

  function automatic logic [7:0] esc_lo(input logic [7:0] b);
    return (b == FLAG_BYTE) ? ESC_FLAG_LO : ESC_ESC_LO;
  endfunction

endpackage

FILE: hw/rtl/fsfe_if.sv
// valid/ready channel interfaces for payload input and line output
interface fsfe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       payload_end;

  modport source (output valid, output payload_byte, output payload_end, input ready);
  modport sink (input valid, input payload_byte, input payload_end, output ready);
endinterface

interface fsfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_byte;
  logic       run_last;
  logic       frame_done;

  modport source (output valid, output line_byte, output run_last, output frame_done,
                  input ready);
  modport sink (input valid, input line_byte, input run_last, input frame_done,
                output ready);
endinterface

FILE: hw/rtl/fsfe_expand.sv
// frame state and expansion of one payload byte into its registered line-byte burst
module fsfe_expand (
  input  logic            clk,
  input  logic            rst,
  fsfe_in_if.sink         payload,
  output logic            burst_valid,
  output fsfe_pkg::burst_t burst,
  input  logic            burst_take
);
  import fsfe_pkg::*;

  logic [7:0] check;
  logic       frame_open;
  logic       accept;
  logic [7:0] check_next;
  burst_t     burst_next;
  idx_t       k;

  assign payload.ready = !burst_valid || burst_take;
  assign accept        = payload.valid && payload.ready;
  assign check_next    = check ^ payload.payload_byte;

  always_comb begin
    k          = '0;
    burst_next = '0;
    if (!frame_open) begin
      burst_next.data[k] = FLAG_BYTE;
      k = k + 3'd1;
    end
    if (needs_esc(payload.payload_byte)) begin
      burst_next.data[k]        = ESC_BYTE;
      burst_next.data[k + 3'd1] = esc_lo(payload.payload_byte);
      k = k + 3'd2;
    end else begin
      burst_next.data[k] = payload.payload_byte;
      k = k + 3'd1;
    end
    if (payload.payload_end) begin
      if (needs_esc(check_next)) begin
        burst_next.data[k]        = ESC_BYTE;
        burst_next.data[k + 3'd1] = esc_lo(check_next);
        k = k + 3'd2;
      end else begin
        burst_next.data[k] = check_next;
        k = k + 3'd1;
      end
      burst_next.data[k] = FLAG_BYTE;
      k = k + 3'd1;
    end
    burst_next.last_idx = k - 3'd1;
    burst_next.closes   = payload.payload_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      burst_valid <= 1'b0;
      check       <= 8'h00;
      frame_open  <= 1'b0;
    end else if (accept) begin
      burst_valid <= 1'b1;
      check       <= payload.payload_end ? 8'h00 : check_next;
      frame_open  <= !payload.payload_end;
    end else if (burst_take) begin
      burst_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      burst <= burst_next;
    end
  end

endmodule

FILE: hw/rtl/fsfe_serial.sv
// serializer that walks one burst out onto the line a byte per cycle while line.ready is high
module fsfe_serial (
  input  logic             clk,
  input  logic             rst,
  input  logic             burst_valid,
  input  fsfe_pkg::burst_t burst,
  output logic             burst_take,
  fsfe_out_if.source       line
);
  import fsfe_pkg::*;

  burst_t cur;
  logic   cur_valid;
  idx_t   idx;
  logic   at_last;
  logic   line_take;

  assign at_last    = (idx == cur.last_idx);
  assign line_take  = line.valid && line.ready;
  assign burst_take = burst_valid && (!cur_valid || (line_take && at_last));

  assign line.valid      = cur_valid;
  assign line.line_byte  = cur.data[idx];
  assign line.run_last   = at_last;
  assign line.frame_done = at_last && cur.closes;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (burst_take) begin
      cur_valid <= 1'b1;
      idx       <= '0;
    end else if (line_take) begin
      if (at_last) begin
        cur_valid <= 1'b0;
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (burst_take) begin
      cur <= burst;
    end
  end

endmodule

FILE: hw/rtl/flag_stuffed_frame_encoder_xor.sv
// top level of the flag-delimited byte-stuffed framer with xor check byte
//
//   channel   dir  fields                              request when
//   payload   in   payload_byte[7:0], payload_end      valid && ready
//   line      out  line_byte[7:0], run_last,           valid && ready
//                  frame_done
//
// each request becomes a burst of 1 to 6 line bytes, held in the burst register
// the line side sends one byte per cycle while line.ready is high; a burst holds
// just one byte for a plain byte inside an open frame
// a second request is held in the burst register while the serializer drains
// rst is synchronous and active high; it drops any open frame and pending bytes
// a stall on line holds the current byte and backs up into payload.ready
`include "flag_stuffed_frame_encoder_xor_assert.svh"

module flag_stuffed_frame_encoder_xor (
  input  logic       clk,
  input  logic       rst,
  fsfe_in_if.sink    payload,
  fsfe_out_if.source line
);
  import fsfe_pkg::*;

  logic   burst_valid;
  burst_t burst;
  logic   burst_take;

  fsfe_expand u_expand (
    .clk         (clk),
    .rst         (rst),
    .payload     (payload),
    .burst_valid (burst_valid),
    .burst       (burst),
    .burst_take  (burst_take)
  );

  fsfe_serial u_serial (
    .clk         (clk),
    .rst         (rst),
    .burst_valid (burst_valid),
    .burst       (burst),
    .burst_take  (burst_take),
    .line        (line)
  );

  // closing flag is always the final byte of its burst
  `FSFE_ASSERT_IMPLIES(a_done_is_flag, clk, rst, line.valid && line.frame_done, line.run_last && (line.line_byte == FLAG_BYTE))
  // a waiting burst stays put until the serializer loads it
  `FSFE_ASSERT_NEXT(a_burst_held, clk, rst, burst_valid && !burst_take, burst_valid && $stable(burst))
  // a new burst loads only into an empty serializer or on its last byte
  `FSFE_ASSERT_IMPLIES(a_load_clean, clk, rst, burst_take, !line.valid || (line.ready && line.run_last))

endmodule

FILE: test/flag_stuffed_frame_encoder_xor_tb.sv
// self-checking testbench for the flag-stuffed xor framer: frames are predicted and checked bytewise
`timescale 1ns / 1ps

module flag_stuffed_frame_encoder_xor_tb;
  import fsfe_pkg::FLAG_BYTE;
  import fsfe_pkg::ESC_BYTE;
  import fsfe_pkg::ESC_FLAG_LO;
  import fsfe_pkg::ESC_ESC_LO;

  localparam int RandomPerPhase = 160;
  localparam int HoldCycles     = 300;
  localparam int DrainCycles    = 20;
  localparam longint LimitNs    = 64'd2_000_000;

  typedef struct {
    logic [7:0] payload_byte;
    logic       payload_end;
  } payload_req_t;

  typedef struct {
    logic [7:0] line_byte;
    logic       run_last;
    logic       frame_done;
  } line_rec_t;

  logic clk;
  logic rst;

  fsfe_in_if  payload_ch ();
  fsfe_out_if line_ch ();

  flag_stuffed_frame_encoder_xor uut (
    .clk    (clk),
    .rst    (rst),
    .payload(payload_ch),
    .line   (line_ch)
  );

  payload_req_t pending_reqs[$];
  line_rec_t    expected_line[$];

  // predictor state
  logic [7:0] pred_check;
  logic       pred_open;

  // generator state, tracks the xor of the frame being queued
  logic [7:0] gen_check;

  int phase;
  int send_idle_pct;
  int recv_idle_pct;
  int in_count;
  int out_count;
  int frames_seen;
  int err_count;
  int hold_from;
  int hold_left;
  bit hold_done;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always_comb begin
    case (phase)
      0: begin
        send_idle_pct = 19;
        recv_idle_pct = 50;
      end
      1: begin
        send_idle_pct = 50;
        recv_idle_pct = 19;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at line byte %0d: %s got 0x%0h want 0x%0h", out_count, what, got, want);
    err_count++;
  endtask

  function automatic void push_stuffed(ref line_rec_t burst[$], input logic [7:0] b);
    if (b == FLAG_BYTE || b == ESC_BYTE) begin
      burst.push_back('{ESC_BYTE, 1'b0, 1'b0});
      burst.push_back('{(b == FLAG_BYTE) ? ESC_FLAG_LO : ESC_ESC_LO, 1'b0, 1'b0});
    end else begin
      burst.push_back('{b, 1'b0, 1'b0});
    end
  endfunction

  // works out the line bytes one accepted request causes
  function automatic void predict_line_bytes(input logic [7:0] b, input logic last);
    line_rec_t burst[$];
    if (!pred_open) begin
      burst.push_back('{FLAG_BYTE, 1'b0, 1'b0});
      pred_open = 1'b1;
    end
    push_stuffed(burst, b);
    pred_check = pred_check ^ b;
    if (last) begin
      push_stuffed(burst, pred_check);
      burst.push_back('{FLAG_BYTE, 1'b0, 1'b1});
      pred_check = 8'h00;
      pred_open  = 1'b0;
    end
    burst[burst.size() - 1].run_last = 1'b1;
    foreach (burst[i]) expected_line.push_back(burst[i]);
  endfunction

  // payload driver
  always @(posedge clk) begin : payload_driver
    bit fire;
    fire = payload_ch.valid && payload_ch.ready;
    if (rst) begin
      payload_ch.valid <= 1'b0;
      in_count         <= 0;
    end else begin
      if (fire) begin
        predict_line_bytes(payload_ch.payload_byte, payload_ch.payload_end);
        in_count <= in_count + 1;
      end
      if (!payload_ch.valid || fire) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          payload_ch.valid        <= 1'b1;
          payload_ch.payload_byte <= pending_reqs[0].payload_byte;
          payload_ch.payload_end  <= pending_reqs[0].payload_end;
          void'(pending_reqs.pop_front());
        end else begin
          payload_ch.valid        <= 1'b0;
          payload_ch.payload_byte <= 8'($urandom);
          payload_ch.payload_end  <= 1'($urandom);
        end
      end
    end
  end

  // long receiver hold-off in the last phase, so the input backs up
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (phase == 2 && !hold_done && in_count >= hold_from) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      line_ch.ready <= 1'b0;
    end else begin
      line_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // line monitor
  always @(posedge clk) begin : line_monitor
    line_rec_t want;
    if (!rst && line_ch.valid && line_ch.ready) begin
      if (expected_line.size() == 0) begin
        $display("unexpected line byte 0x%0h with nothing pending", line_ch.line_byte);
        err_count++;
      end else begin
        want = expected_line.pop_front();
        if (line_ch.line_byte !== want.line_byte)
          report_mismatch("line_byte", line_ch.line_byte, want.line_byte);
        if (line_ch.run_last !== want.run_last)
          report_mismatch("run_last", line_ch.run_last, want.run_last);
        if (line_ch.frame_done !== want.frame_done)
          report_mismatch("frame_done", line_ch.frame_done, want.frame_done);
      end
      if (line_ch.frame_done === 1'b1) frames_seen++;
      out_count++;
    end
  end

  task automatic queue_req(input logic [7:0] b, input logic last);
    pending_reqs.push_back('{b, last});
    gen_check = last ? 8'h00 : (gen_check ^ b);
  endtask

  // queues one frame, heavy on flag and escape bytes, and sometimes forces
  // the check byte itself to need stuffing
  task automatic queue_random_frame(ref int count);
    int len;
    logic [7:0] b;
    len = ($urandom_range(9) == 0) ? $urandom_range(20, 7) : $urandom_range(6, 1);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(9))
        0, 1: b = FLAG_BYTE;
        2, 3: b = ESC_BYTE;
        default: b = 8'($urandom);
      endcase
      if (i == len - 1 && $urandom_range(3) == 0)
        b = gen_check ^ ($urandom_range(1) ? FLAG_BYTE : ESC_BYTE);
      queue_req(b, i == len - 1);
      count++;
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || payload_ch.valid || expected_line.size() != 0);
    repeat (DrainCycles) @(negedge clk);
  endtask

  initial begin
    int count;
    rst                     = 1'b1;
    phase                   = 0;
    hold_from               = 0;
    out_count               = 0;
    frames_seen             = 0;
    err_count               = 0;
    pred_check              = 8'h00;
    pred_open               = 1'b0;
    gen_check               = 8'h00;
    payload_ch.valid        = 1'b0;
    payload_ch.payload_byte = 8'h00;
    payload_ch.payload_end  = 1'b0;
    line_ch.ready           = 1'b0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // single-byte frames at the extremes and on both escaped values
    queue_req(8'h00, 1'b1);
    queue_req(8'hFF, 1'b1);
    queue_req(FLAG_BYTE, 1'b1);
    queue_req(ESC_BYTE, 1'b1);
    // check byte comes out as a flag and as an escape
    queue_req(8'h7F, 1'b0);
    queue_req(8'h01, 1'b1);
    queue_req(8'h7C, 1'b0);
    queue_req(8'h01, 1'b1);
    // escapes mid-frame, longer frame
    queue_req(FLAG_BYTE, 1'b0);
    queue_req(ESC_BYTE, 1'b0);
    queue_req(8'h00, 1'b0);
    queue_req(8'hFF, 1'b0);
    queue_req(8'h55, 1'b0);
    queue_req(8'hAA, 1'b1);
    // check byte of zero
    queue_req(8'h5E, 1'b0);
    queue_req(8'h5E, 1'b1);

    count = 0;
    while (count < RandomPerPhase) queue_random_frame(count);
    wait_idle();

    phase = 1;
    count = 0;
    while (count < RandomPerPhase) queue_random_frame(count);
    wait_idle();

    phase     = 2;
    hold_from = in_count + 8;
    count     = 0;
    while (count < RandomPerPhase) queue_random_frame(count);
    wait_idle();

    if (expected_line.size() != 0) begin
      $display("%0d expected line bytes never arrived", expected_line.size());
      err_count++;
    end
    $display("covered %0d payload requests, %0d line bytes, %0d closed frames",
             in_count, out_count, frames_seen);
    $display("three idle mixes plus a %0d-cycle line stall; %0d mismatches", HoldCycles,
             err_count);
    if (err_count == 0) begin
      $display("flag_stuffed_frame_encoder_xor_tb: done, clean");
    end else begin
      $display("flag_stuffed_frame_encoder_xor_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #(LimitNs);
    $display("timeout with %0d line bytes still expected", expected_line.size());
    $display("flag_stuffed_frame_encoder_xor_tb: done, errors");
    $finish;
  end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/fsfe_pkg.sv
hw/rtl/fsfe_if.sv
hw/rtl/fsfe_expand.sv
hw/rtl/fsfe_serial.sv
hw/rtl/flag_stuffed_frame_encoder_xor.sv
test/flag_stuffed_frame_encoder_xor_tb.sv
